// ===== design/aips_pkg.sv =====
`timescale 1ns / 1ps
package aips_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned MaxSends = 3;
  localparam int unsigned MaxChars = 7;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_BUS   = 2'd1,
    KIND_BEGIN = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_DEVICE_ADDRESS   = 3'd0,
    REG_CONTROL_REGISTER = 3'd1,
    REG_CONTROL_VALUE    = 3'd2,
    REG_X_REGISTER       = 3'd3,
    REG_Y_REGISTER       = 3'd4
  } reg_idx_e;

  localparam logic [1:0] BufIrqKeep    = 2'd0;
  localparam logic [1:0] BufIrqEnable  = 2'd1;
  localparam logic [1:0] BufIrqDisable = 2'd2;

  localparam logic [7:0] CharX     = 8'h58;
  localparam logic [7:0] CharY     = 8'h59;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;

  typedef struct packed {
    logic [1:0]        kind;
    logic              start_sent;
    logic              address_sent;
    logic              tx_empty;
    logic              byte_done;
    logic              rx_full;
    logic signed [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       request_start;
    logic       request_stop;
    logic       clear_ack;
    logic [1:0] buffer_irq;
    logic       timer_enable;
    logic       char_valid;
    logic [7:0] char_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] control_register;
    logic [7:0] control_value;
    logic [7:0] x_register;
    logic [7:0] y_register;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    device_address:   7'h1c,
    control_register: 8'h20,
    control_value:    8'h47,
    x_register:       8'h29,
    y_register:       8'h2b
  };

  typedef struct packed {
    logic                      request_start;
    logic                      request_stop;
    logic                      clear_ack;
    logic [1:0]                buffer_irq;
    logic                      timer_enable;
  } pulses_t;

  typedef struct packed {
    logic [MaxSends-1:0][7:0] sends;
    logic [1:0]               nsend;
    logic [MaxChars-1:0][7:0] chars;
    logic [2:0]               nchar;
    logic [2:0]               nres;
    pulses_t                  pulses;
  } job_t;

endpackage

// ===== design/aips_front.sv =====
`timescale 1ns / 1ps
module aips_front import aips_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  in_item_t item_i,
  input  logic     accept_i,
  output job_t     job_o
);

  logic initialised_q, initialised_d;
  logic second_start_q, second_start_d;
  logic axis_is_y_q, axis_is_y_d;

  logic [7:0]  dev;
  logic [7:0]  raw;
  logic [7:0]  mag;
  logic        hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  units_w;
  logic [3:0]  units;
  logic [1:0]  ns;
  logic [2:0]  nc;
  job_t        job;

  // binary to decimal, value at most 128
  always_comb begin
    raw     = item_i.rx_byte;
    mag     = raw[7] ? 8'(-raw) : raw;
    hund    = (mag >= 8'd100);
    rem     = hund ? 7'(mag - 8'd100) : mag[6:0];
    prod    = 15'(rem) * 15'd205;
    tens    = prod[14:11];
    units_w = rem - {tens, 3'b000} - {2'b00, tens, 1'b0};
    units   = units_w[3:0];
  end

  always_comb begin
    dev            = {cfg_i.device_address, 1'b0};
    job            = '0;
    ns             = '0;
    nc             = '0;
    initialised_d  = initialised_q;
    second_start_d = second_start_q;
    axis_is_y_d    = axis_is_y_q;

    unique case (item_i.kind)
      KIND_TICK: begin
        if (initialised_q) begin
          second_start_d           = 1'b0;
          axis_is_y_d              = 1'b0;
          job.pulses.request_start = 1'b1;
          job.pulses.buffer_irq    = BufIrqEnable;
        end
      end
      KIND_BEGIN: job.pulses.request_start = 1'b1;
      KIND_ERROR: job.pulses.request_stop = 1'b1;
      default: begin
        if (item_i.start_sent) begin
          if (!initialised_q || !second_start_q) begin
            job.sends[ns] = dev;
          end else begin
            job.sends[ns]        = dev | 8'h01;
            job.pulses.clear_ack = 1'b1;
          end
          ns = ns + 2'd1;
        end
        if (item_i.address_sent) begin
          if (!initialised_q) begin
            job.sends[ns] = cfg_i.control_register;
            ns = ns + 2'd1;
          end else if (!second_start_q) begin
            job.sends[ns] = axis_is_y_q ? cfg_i.y_register : cfg_i.x_register;
            ns = ns + 2'd1;
          end else begin
            job.pulses.request_stop = 1'b1;
          end
        end
        if (!initialised_q) begin
          if (item_i.tx_empty) begin
            job.sends[ns]         = cfg_i.control_value;
            ns                    = ns + 2'd1;
            job.pulses.buffer_irq = BufIrqDisable;
          end
          if (item_i.byte_done) begin
            initialised_d           = 1'b1;
            job.pulses.request_stop = 1'b1;
            job.pulses.timer_enable = 1'b1;
          end
        end else if (item_i.byte_done && !second_start_q) begin
          second_start_d           = 1'b1;
          job.pulses.request_start = 1'b1;
        end
        if (item_i.rx_full) begin
          job.chars[nc] = axis_is_y_q ? CharY : CharX;
          nc = nc + 3'd1;
          if (raw[7]) begin
            job.chars[nc] = CharMinus;
            nc = nc + 3'd1;
          end
          if (hund) begin
            job.chars[nc] = CharZero + 8'd1;
            nc = nc + 3'd1;
          end
          if (hund || rem >= 7'd10) begin
            job.chars[nc] = CharZero + 8'(tens);
            nc = nc + 3'd1;
          end
          job.chars[nc] = CharZero + 8'(units);
          nc = nc + 3'd1;
          if (axis_is_y_q) begin
            job.chars[nc] = CharCr;
            nc = nc + 3'd1;
            job.chars[nc] = CharLf;
            nc = nc + 3'd1;
            job.pulses.buffer_irq = BufIrqDisable;
          end else begin
            axis_is_y_d              = 1'b1;
            second_start_d           = 1'b0;
            job.pulses.request_start = 1'b1;
          end
        end
      end
    endcase

    job.nsend = ns;
    job.nchar = nc;
    if (nc == 3'd0 && ns == 2'd0) begin
      job.nres = 3'd1;
    end else if (3'(ns) > nc) begin
      job.nres = 3'(ns);
    end else begin
      job.nres = nc;
    end
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initialised_q  <= 1'b0;
      second_start_q <= 1'b0;
      axis_is_y_q    <= 1'b0;
    end else if (accept_i) begin
      initialised_q  <= initialised_d;
      second_start_q <= second_start_d;
      axis_is_y_q    <= axis_is_y_d;
    end
  end

endmodule

// ===== design/aips_queue.sv =====
`timescale 1ns / 1ps
module aips_queue import aips_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_job_i,
  input  logic rd_i,
  output job_t rd_job_o,
  output logic full_o,
  output logic nonempty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nonempty_o = (cnt_q != '0);
  assign rd_job_o   = mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= nxt(wptr_q);
      end
      if (rd_i) begin
        rptr_q <= nxt(rptr_q);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== design/aips_back.sv =====
`timescale 1ns / 1ps
module aips_back import aips_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      job_take_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t item_o
);

  job_t       cur_q;
  logic       cur_valid_q;
  logic [2:0] idx_q, idx_d;
  logic       is_last;
  logic       take;
  logic       send_v;
  logic       char_v;

  assign is_last    = (idx_q == cur_q.nres - 3'd1);
  assign take       = job_valid_i && (!cur_valid_q || (pop_i && is_last));
  assign job_take_o = take;
  assign empty_o    = !cur_valid_q;

  assign send_v = (idx_q < 3'(cur_q.nsend));
  assign char_v = (idx_q < cur_q.nchar);

  always_comb begin
    item_o            = '0;
    item_o.send_valid = send_v;
    item_o.send_byte  = send_v ? cur_q.sends[idx_q[1:0]] : 8'h00;
    item_o.char_valid = char_v;
    item_o.char_byte  = char_v ? cur_q.chars[idx_q] : 8'h00;
    item_o.last       = is_last;
    if (idx_q == 3'd0) begin
      item_o.request_start = cur_q.pulses.request_start;
      item_o.request_stop  = cur_q.pulses.request_stop;
      item_o.clear_ack     = cur_q.pulses.clear_ack;
      item_o.buffer_irq    = cur_q.pulses.buffer_irq;
      item_o.timer_enable  = cur_q.pulses.timer_enable;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (pop_i && cur_valid_q) begin
      idx_d = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      idx_q <= idx_d;
      if (take) begin
        cur_valid_q <= 1'b1;
      end else if (pop_i && cur_valid_q && is_last) begin
        cur_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== design/accel_i2c_poll_sequencer.sv =====
`timescale 1ns / 1ps
// Sequences an I2C master through one control register write and then periodic X/Y
// sample reads, and formats each sample as an ASCII record. Requests enter through a
// push/full port and are classified in the same cycle into bus actions and record
// characters; a short queue (QueueDepth entries) feeds the back end, which hands out
// one result per cycle on the empty/pop port while pop is high. A request yields
// max(bytes to send, record characters, 1) results, 1 to 7. With the back end idle,
// an accepted request is queued and then loaded into the back end's job register,
// which shows its first result. A new request is taken every cycle while the queue
// has room. Registers sit at byte offsets 0x00 to 0x10 of the APB port. The user
// must change them only while no request is in flight; the block does not check it.
module accel_i2c_poll_sequencer import aips_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     accept;
  logic     q_full;
  logic     q_nonempty;
  logic     q_take;
  job_t     front_job;
  job_t     head_job;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_DEVICE_ADDRESS:   cfg_q.device_address   <= pwdata[6:0];
        REG_CONTROL_REGISTER: cfg_q.control_register <= pwdata[7:0];
        REG_CONTROL_VALUE:    cfg_q.control_value    <= pwdata[7:0];
        REG_X_REGISTER:       cfg_q.x_register       <= pwdata[7:0];
        REG_Y_REGISTER:       cfg_q.y_register       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEVICE_ADDRESS:   prdata = 32'(cfg_q.device_address);
      REG_CONTROL_REGISTER: prdata = 32'(cfg_q.control_register);
      REG_CONTROL_VALUE:    prdata = 32'(cfg_q.control_value);
      REG_X_REGISTER:       prdata = 32'(cfg_q.x_register);
      REG_Y_REGISTER:       prdata = 32'(cfg_q.y_register);
      default:              prdata = '0;
    endcase
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  aips_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (in_item_i),
    .accept_i (accept),
    .job_o    (front_job)
  );

  aips_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept),
    .wr_job_i   (front_job),
    .rd_i       (q_take),
    .rd_job_o   (head_job),
    .full_o     (q_full),
    .nonempty_o (q_nonempty)
  );

  aips_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .job_valid_i (q_nonempty),
    .job_take_o  (q_take),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

endmodule

// ===== design/aips_checker.sv =====
`timescale 1ns / 1ps
module aips_checker import aips_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_item_o))
    else $error("waiting result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !out_item_o.last |=> !empty && !out_item_o.request_start &&
      !out_item_o.request_stop && !out_item_o.clear_ack &&
      out_item_o.buffer_irq == BufIrqKeep && !out_item_o.timer_enable)
    else $error("control pulse outside first result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.send_valid || out_item_o.send_byte == 8'h00) &&
      (out_item_o.char_valid || out_item_o.char_byte == 8'h00))
    else $error("byte without valid is not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full && empty |=> ##1 !empty)
    else $error("request accepted while idle gave no result");

endmodule

bind accel_i2c_poll_sequencer aips_checker u_aips_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
